/* sv/ght_pkg.sv */
// shared types and constants of the generational handle table
// no dependencies; used by generational_handle_table and ght_eval

package ght_pkg;

    localparam int ENTRIES_DEFAULT = 1024;
    localparam int HANDLE_BITS     = 32;
    localparam int OWNER_BITS      = 32;
    localparam int COUNT_BITS      = 11;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_FREE   = 2'd2,
        CMD_CHECK  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_STALE = 2'd2,
        ST_OWNER = 2'd3
    } status_t;

    // outcome of one request, from the evaluation logic to the top level
    typedef struct packed {
        status_t status;
        logic    take;      // entry leaves the free list
        logic    give_back; // entry is released to the free list tail
    } eval_t;

endpackage

/* sv/generational_handle_table.sv */
// Generational handle table. A handle carries an entry index in its low
// $clog2(ENTRIES) bits and an instance count in the bits above. Allocate pops
// the head of a first-in first-out free list, stores the owner and returns the
// handle (status table full when the list is empty); cancel and check compare
// handle, occupied bit and owner, free compares only handle and occupied bit;
// cancel and free bump the instance (all ones wraps to one) and append the entry
// at the list tail. The entry memory and the free-list link memory are read in
// the cycle the request is accepted; any entry update is written back in the
// execute state once the result register has room, so a new request is taken
// only after the previous one has left the execute state. After reset the block
// sweeps both memories once and accepts no request until it is done.
// Depends on ght_pkg, ght_ram and ght_eval.

module generational_handle_table #(
    parameter int ENTRIES = ght_pkg::ENTRIES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // command
    input  logic [63:0] s_tdata,   // handle [31:0], owner [63:32]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // result_handle [31:0], status [33:32],
                                   // pending_count [44:34], zero fill [47:45]
);

    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int INST_BITS  = ght_pkg::HANDLE_BITS - IDX_BITS;
    localparam int CNT_BITS   = $clog2(ENTRIES + 1);
    localparam int ENTRY_BITS = ght_pkg::OWNER_BITS + INST_BITS + 1;
    localparam int HB         = ght_pkg::HANDLE_BITS;
    localparam int OB         = ght_pkg::OWNER_BITS;
    localparam int PB         = ght_pkg::COUNT_BITS;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    // control state
    state_t                state_reg,      state_next;
    logic [IDX_BITS-1:0]   clr_idx_reg,    clr_idx_next;
    logic [IDX_BITS-1:0]   free_head_reg,  free_head_next;
    logic [IDX_BITS-1:0]   free_tail_reg,  free_tail_next;
    logic                  free_empty_reg, free_empty_next;
    logic [CNT_BITS-1:0]   count_reg,      count_next;
    logic                  m_valid_reg,    m_valid_next;

    // request held for the write-back cycle
    ght_pkg::cmd_t         cmd_reg;
    logic [HB-1:0]         handle_reg;
    logic [OB-1:0]         owner_reg;
    logic [IDX_BITS-1:0]   idx_reg;

    // result register
    logic [HB-1:0]         res_handle_reg;
    ght_pkg::status_t      res_status_reg;
    logic [PB-1:0]         res_count_reg;

    // memory ports
    logic                  ent_we,   link_we;
    logic [IDX_BITS-1:0]   ent_waddr, link_waddr, ent_raddr;
    logic [ENTRY_BITS-1:0] ent_wdata, ent_rdata;
    logic [IDX_BITS-1:0]   link_wdata, link_rdata;

    // evaluation
    ght_pkg::eval_t        ev;
    logic [INST_BITS-1:0]  inst_next;
    logic [HB-1:0]         result_handle;
    logic                  entry_occ;
    logic [INST_BITS-1:0]  entry_inst;
    logic [OB-1:0]         entry_owner;

    logic                  s_fire;
    logic                  exec_fire;
    logic                  last_clr;
    logic [IDX_BITS:0]     in_idx_ext;
    logic                  in_idx_ok;
    ght_pkg::cmd_t         in_cmd;
    logic [PB+CNT_BITS-1:0] count_ext;

    assign in_cmd    = ght_pkg::cmd_t'(s_tuser);
    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    // write-back only when the result register has room
    assign exec_fire = (state_reg == S_EXEC) && (!m_valid_reg || m_tready);
    assign last_clr  = (clr_idx_reg == IDX_BITS'(ENTRIES - 1));

    // index bits beyond the table read entry zero, the lookup rejects them anyway
    assign in_idx_ext = {1'b0, s_tdata[IDX_BITS-1:0]};
    assign in_idx_ok  = in_idx_ext < (IDX_BITS+1)'(ENTRIES);
    assign ent_raddr  = (in_cmd == ght_pkg::CMD_ALLOC) ? free_head_reg
                      : (in_idx_ok ? s_tdata[IDX_BITS-1:0] : '0);

    // entry word: occupied [0], instance above it, owner on top
    assign entry_occ   = ent_rdata[0];
    assign entry_inst  = ent_rdata[INST_BITS:1];
    assign entry_owner = ent_rdata[ENTRY_BITS-1:INST_BITS+1];

    ght_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (ENTRY_BITS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (s_fire),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    ght_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (IDX_BITS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (s_fire),
        .raddr (free_head_reg),
        .rdata (link_rdata)
    );

    ght_eval #(
        .ENTRIES (ENTRIES)
    ) u_eval (
        .cmd           (cmd_reg),
        .handle        (handle_reg),
        .owner         (owner_reg),
        .idx           (idx_reg),
        .free_empty    (free_empty_reg),
        .entry_occ     (entry_occ),
        .entry_inst    (entry_inst),
        .entry_owner   (entry_owner),
        .ev            (ev),
        .inst_next     (inst_next),
        .result_handle (result_handle)
    );

    // memory writes: clearing sweep after reset, otherwise write-back
    always_comb
    begin
        ent_we     = 1'b0;
        ent_waddr  = idx_reg;
        ent_wdata  = {owner_reg, entry_inst, 1'b1};
        link_we    = 1'b0;
        link_waddr = free_tail_reg;
        link_wdata = idx_reg;
        if (state_reg == S_CLEAR)
        begin
            ent_we     = 1'b1;
            ent_waddr  = clr_idx_reg;
            ent_wdata  = {{OB{1'b0}}, INST_BITS'(1), 1'b0};
            link_we    = 1'b1;
            link_waddr = clr_idx_reg;
            link_wdata = last_clr ? '0 : clr_idx_reg + IDX_BITS'(1);
        end
        else if (exec_fire)
        begin
            if (ev.take)
            begin
                ent_we = 1'b1;
            end
            else if (ev.give_back)
            begin
                ent_we    = 1'b1;
                ent_wdata = {entry_owner, inst_next, 1'b0};
                // append behind the tail unless the list is empty
                link_we   = !free_empty_reg;
            end
        end
    end

    // control next state
    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        free_head_next  = free_head_reg;
        free_tail_next  = free_tail_reg;
        free_empty_next = free_empty_reg;
        count_next      = count_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        case (state_reg)
            S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + IDX_BITS'(1);
                if (last_clr)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                    if (ev.take)
                    begin
                        count_next = count_reg + CNT_BITS'(1);
                        if (free_head_reg == free_tail_reg)
                        begin
                            free_empty_next = 1'b1;
                        end
                        else
                        begin
                            free_head_next = link_rdata;
                        end
                    end
                    else if (ev.give_back)
                    begin
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - CNT_BITS'(1);
                        end
                        free_tail_next = idx_reg;
                        if (free_empty_reg)
                        begin
                            free_head_next  = idx_reg;
                            free_empty_next = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            free_head_reg  <= '0;
            free_tail_reg  <= IDX_BITS'(ENTRIES - 1);
            free_empty_reg <= 1'b0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            free_head_reg  <= free_head_next;
            free_tail_reg  <= free_tail_next;
            free_empty_reg <= free_empty_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            cmd_reg    <= in_cmd;
            handle_reg <= s_tdata[HB-1:0];
            owner_reg  <= s_tdata[HB+OB-1:HB];
            idx_reg    <= ent_raddr;
        end
    end

    // in-use count after this request, low bits onto the result
    assign count_ext = {{PB{1'b0}}, count_next};

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            res_handle_reg <= result_handle;
            res_status_reg <= ev.status;
            res_count_reg  <= count_ext[PB-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, res_count_reg, res_status_reg, res_handle_reg};

endmodule

/* sv/ght_ram.sv */
// simple dual-port synchronous ram, one write and one registered read per cycle
// no package dependencies

module ght_ram #(
    parameter int DEPTH     = 1024,
    parameter int WIDTH     = 32,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/ght_eval.sv */
// evaluation of one request against the entry read from the table
// depends on ght_pkg

module ght_eval #(
    parameter int ENTRIES   = ght_pkg::ENTRIES_DEFAULT,
    parameter int IDX_BITS  = $clog2(ENTRIES),
    parameter int INST_BITS = ght_pkg::HANDLE_BITS - IDX_BITS
) (
    input  ght_pkg::cmd_t                   cmd,
    input  logic [ght_pkg::HANDLE_BITS-1:0] handle,
    input  logic [ght_pkg::OWNER_BITS-1:0]  owner,
    input  logic [IDX_BITS-1:0]             idx,
    input  logic                            free_empty,
    input  logic                            entry_occ,
    input  logic [INST_BITS-1:0]            entry_inst,
    input  logic [ght_pkg::OWNER_BITS-1:0]  entry_owner,
    output ght_pkg::eval_t                  ev,
    output logic [INST_BITS-1:0]            inst_next,
    output logic [ght_pkg::HANDLE_BITS-1:0] result_handle
);

    logic [IDX_BITS:0] hidx_ext;
    logic              in_range;
    logic              match;

    assign hidx_ext = {1'b0, handle[IDX_BITS-1:0]};
    assign in_range = hidx_ext < (IDX_BITS+1)'(ENTRIES);
    assign match    = in_range && entry_occ
                      && (handle[ght_pkg::HANDLE_BITS-1:IDX_BITS] == entry_inst);

    // instance wraps from all ones to one, never to zero
    assign inst_next = (entry_inst == {INST_BITS{1'b1}}) ? INST_BITS'(1)
                                                         : entry_inst + INST_BITS'(1);

    always_comb
    begin
        ev.status     = ght_pkg::ST_OK;
        ev.take       = 1'b0;
        ev.give_back  = 1'b0;
        result_handle = handle;
        case (cmd)
            ght_pkg::CMD_ALLOC:
            begin
                if (free_empty)
                begin
                    ev.status     = ght_pkg::ST_FULL;
                    result_handle = '0;
                end
                else
                begin
                    ev.take       = 1'b1;
                    result_handle = {entry_inst, idx};
                end
            end
            ght_pkg::CMD_CANCEL, ght_pkg::CMD_CHECK:
            begin
                if (!match)
                begin
                    ev.status = ght_pkg::ST_STALE;
                end
                else if (entry_owner != owner)
                begin
                    ev.status = ght_pkg::ST_OWNER;
                end
                else
                begin
                    ev.give_back = (cmd == ght_pkg::CMD_CANCEL);
                end
            end
            ght_pkg::CMD_FREE:
            begin
                if (!match)
                begin
                    ev.status = ght_pkg::ST_STALE;
                end
                else
                begin
                    ev.give_back = 1'b1;
                end
            end
            default:
            begin
                ev.status = ght_pkg::ST_STALE;
            end
        endcase
    end

endmodule
